>>> rtl/sorted_list_table_defines.svh
// Assertion macros used by the sorted list table port checker.
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_list_table: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_list_table: assertion failed");

`endif

>>> rtl/slt_pkg.sv
// Types and constants of the sorted list table.
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

  localparam int SLT_CAPACITY = 64;
  localparam logic [31:0] SLT_NO_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    SLT_OP_APPEND = 2'd0,
    SLT_OP_SORTED = 2'd1,
    SLT_OP_REMOVE = 2'd2,
    SLT_OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SLT_ST_DONE  = 2'd0,
    SLT_ST_FULL  = 2'd1,
    SLT_ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    status_e            status;
    logic [6:0]         count;
  } out_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               cmp_en;
    logic signed [31:0] cmp_value;
    logic               exec;
    op_e                op;
    logic signed [31:0] value;
    logic               full;
    logic               rm_ok;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/slt_cell.sv
// One list entry with its local compare and shift logic.
`timescale 1ns / 1ps
`default_nettype none

module slt_cell #(
  parameter int Idx = 0,
  parameter int W   = 7
) (
  input  wire logic               clk_i,
  input  wire slt_pkg::ctl_t      ctl_i,
  input  wire logic [W-1:0]       count_i,
  input  wire logic [W-1:0]       pos_i,
  input  wire logic signed [31:0] left_entry_i,
  input  wire logic signed [31:0] right_entry_i,
  input  wire logic               seen_i,
  output logic signed [31:0]      entry_o,
  output logic                    seen_o,
  output logic [31:0]             pick_o
);

  localparam logic [W-1:0] MyIdx = W'(Idx);

  logic signed [31:0] entry_q, entry_d;
  logic               ge_q;
  logic               valid;
  logic               at_tail;
  logic               at_pos;

  assign valid   = MyIdx < count_i;
  assign at_tail = MyIdx == count_i;
  assign at_pos  = MyIdx == pos_i;

  // Register whether this entry is a valid one not smaller than the new value.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp_en) begin
      ge_q <= valid && !(entry_q < ctl_i.cmp_value);
    end
  end

  // This cell or some cell to its left holds the insert point.
  assign seen_o = seen_i | ge_q;

  // Pick the next entry: keep, load the new value, or take a neighbor.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.exec) begin
      case (ctl_i.op)
        slt_pkg::SLT_OP_APPEND: begin
          if (!ctl_i.full && at_tail) entry_d = ctl_i.value;
        end
        slt_pkg::SLT_OP_SORTED: begin
          if (!ctl_i.full) begin
            if (seen_i) entry_d = left_entry_i;
            else if (ge_q || at_tail) entry_d = ctl_i.value;
          end
        end
        slt_pkg::SLT_OP_REMOVE: begin
          if (ctl_i.rm_ok && (MyIdx >= pos_i)) entry_d = right_entry_i;
        end
        default: begin
          entry_d = entry_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign pick_o  = at_pos ? entry_q : '0;

endmodule

`default_nettype wire

>>> rtl/sorted_list_table.sv
// Top level of the sorted list table: controller, output register and cell row.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------
//  in      | in  | in_valid_i/in_stall_o   | in_data_i  (operation, value, position)
//  out     | out | out_valid_o/out_stall_i | out_data_o (removed_value, status, count)
//
// Each operation runs in an accept cycle, which registers one compare per
// cell, and then in the execute cycle, which ripples the insert point down
// the row and shifts.
// Reset clears the entry count and the handshake state; entries stay undefined.
// A result waits in the output register; a new operation is refused only while
// one is executing or the waiting result is stalled.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_table #(
  parameter int CAPACITY = slt_pkg::SLT_CAPACITY
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire slt_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output slt_pkg::out_t     out_data_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int W    = (CntW > 6) ? CntW : 6;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q, out_valid_d;
  slt_pkg::out_t      out_q, out_d;
  slt_pkg::op_e       op_q;
  logic signed [31:0] val_q;
  logic [5:0]         pos_q;

  logic               accept;
  logic               exec;
  logic [W-1:0]       count_w;
  logic [W-1:0]       pos_w;
  slt_pkg::ctl_t      ctl;
  logic [31:0]        removed;

  logic signed [31:0] entry   [CAPACITY];
  logic [31:0]        pick    [CAPACITY];
  logic               seen    [CAPACITY+1];

  assign accept     = in_valid_i && !in_stall_o;
  assign exec       = state_q == ST_EXEC;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign count_w    = W'(count_q);
  assign pos_w      = W'(pos_q);

  // Broadcast control to the row.
  always_comb begin
    ctl.cmp_en    = accept;
    ctl.cmp_value = in_data_i.value;
    ctl.exec      = exec;
    ctl.op        = op_q;
    ctl.value     = val_q;
    ctl.full      = count_q == CntW'(CAPACITY);
    ctl.rm_ok     = pos_w < count_w;
  end

  // Build the row of cells.
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = val_q;
    end else begin : g_mid
      assign left_e = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_inner
      assign right_e = entry[i+1];
    end
    slt_cell #(
      .Idx (i),
      .W   (W)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .count_i       (count_w),
      .pos_i         (pos_w),
      .left_entry_i  (left_e),
      .right_entry_i (right_e),
      .seen_i        (seen[i]),
      .entry_o       (entry[i]),
      .seen_o        (seen[i+1]),
      .pick_o        (pick[i])
    );
  end

  // Merge the entry at the remove position.
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | pick[i];
    end
  end

  // Hold the operation for the execute cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_data_i.operation;
      val_q <= in_data_i.value;
      pos_q <= in_data_i.position;
    end
  end

  // Sequence, count update and result register.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d                = ST_IDLE;
        out_valid_d            = 1'b1;
        out_d.removed_value    = slt_pkg::SLT_NO_VALUE;
        out_d.status           = slt_pkg::SLT_ST_DONE;
        case (op_q)
          slt_pkg::SLT_OP_APPEND, slt_pkg::SLT_OP_SORTED: begin
            if (ctl.full) out_d.status = slt_pkg::SLT_ST_FULL;
            else count_d = count_q + CntW'(1);
          end
          slt_pkg::SLT_OP_REMOVE: begin
            if (ctl.rm_ok) begin
              out_d.removed_value = removed;
              count_d             = count_q - CntW'(1);
            end else begin
              out_d.status = slt_pkg::SLT_ST_RANGE;
            end
          end
          default: begin
            count_d = '0;
          end
        endcase
        out_d.count = 7'(count_d);
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/slt_checker.sv
// Port-level checks of the sorted list table and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_list_table_defines.svh"

module slt_checker #(
  parameter int CAPACITY = slt_pkg::SLT_CAPACITY
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire slt_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire slt_pkg::out_t out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // A stalled result beat holds.
  `SLT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // An accepted beat blocks the input while it executes.
  `SLT_ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall_o)

  // Every accepted beat shows its result from the result register once it has executed.
  `SLT_ASSERT_NOW(a_result_follows, in_beat, ##2 out_valid_o)

  // Only a completed operation carries a value other than all ones.
  `SLT_ASSERT_NOW(a_no_value_on_error, out_valid_o && (out_data_o.status != slt_pkg::SLT_ST_DONE), out_data_o.removed_value == slt_pkg::SLT_NO_VALUE)

  // The count never passes the capacity.
  `SLT_ASSERT_NOW(a_count_bound, out_valid_o, (CAPACITY > 127) || (int'(out_data_o.count) <= CAPACITY))

endmodule

bind sorted_list_table slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);

`default_nettype wire

>>> sim/sorted_list_checker.sv
// Shadow list, reply prediction and comparison for the sorted list table.
`timescale 1ns / 1ps

module sorted_list_checker #(
  parameter int CAPACITY = slt_pkg::SLT_CAPACITY
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  wire slt_pkg::in_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_stall_i,
  input  wire slt_pkg::out_t out_data_i,
  output int                 mismatch_count_o,
  output int                 replies_owed_o,
  output int                 list_fill_o
);

  // Shadow copy of the list contents, head first
  logic signed [31:0] shadow_list[$];
  // Replies owed by the block, oldest first
  slt_pkg::out_t      owed_replies[$];
  slt_pkg::out_t      oldest_reply;

  // Apply one operation to the shadow list and return the reply it earns
  function automatic slt_pkg::out_t apply_list_op(slt_pkg::in_t beat);
    slt_pkg::out_t reply;
    int            slot;
    reply.removed_value = slt_pkg::SLT_NO_VALUE;
    reply.status        = slt_pkg::SLT_ST_DONE;
    case (beat.operation)
      slt_pkg::SLT_OP_APPEND, slt_pkg::SLT_OP_SORTED: begin
        if (shadow_list.size() >= CAPACITY) begin
          reply.status = slt_pkg::SLT_ST_FULL;
        end else if (beat.operation == slt_pkg::SLT_OP_APPEND) begin
          shadow_list.push_back(beat.value);
        end else begin
          // first entry not smaller than the value, even if appends broke the order
          slot = 0;
          while (slot < shadow_list.size() && shadow_list[slot] < beat.value) begin
            slot++;
          end
          shadow_list.insert(slot, beat.value);
        end
      end
      slt_pkg::SLT_OP_REMOVE: begin
        if (int'(beat.position) < shadow_list.size()) begin
          reply.removed_value = shadow_list[beat.position];
          shadow_list.delete(beat.position);
        end else begin
          reply.status = slt_pkg::SLT_ST_RANGE;
        end
      end
      default: begin
        shadow_list.delete();
      end
    endcase
    reply.count = 7'(shadow_list.size());
    return reply;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      mismatch_count_o++;
    end
  endtask

  // Retire the result beat first, then predict the input beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_list.delete();
      owed_replies.delete();
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_replies.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h/%0d/%0d", $time,
                   out_data_i.removed_value, out_data_i.status, out_data_i.count);
          mismatch_count_o++;
        end else begin
          oldest_reply = owed_replies.pop_front();
          check_field("removed_value", oldest_reply.removed_value,
                      out_data_i.removed_value);
          check_field("status", 32'(oldest_reply.status), 32'(out_data_i.status));
          check_field("count", 32'(oldest_reply.count), 32'(out_data_i.count));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        owed_replies.push_back(apply_list_op(in_data_i));
      end
    end
    replies_owed_o = owed_replies.size();
    list_fill_o    = shadow_list.size();
  end

endmodule

>>> sim/tb_top.sv
// Stimulus, flow control and verdict for the sorted list table.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIST_DEPTH   = slt_pkg::SLT_CAPACITY;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 8;

  // Shape of one random run of operations
  typedef enum int {FILL_RUN, DRAIN_RUN, MIXED_RUN, NOISE_RUN} run_kind_e;
  // Receiver stall styles
  typedef enum int {RX_OPEN, RX_HALF, RX_LIGHT, RX_BLOCK} stall_style_e;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  slt_pkg::in_t  in_data   = '0;
  logic          out_stall = 1'b0;
  logic          in_stall;
  logic          out_valid;
  slt_pkg::out_t out_data;
  logic          in_taken  = 1'b0;

  int           mismatches;
  int           replies_owed;
  int           list_fill;
  int           burst_left  = 0;
  int           quiet_count = 0;
  int           stall_left  = 0;
  stall_style_e stall_style = RX_OPEN;

  sorted_list_table u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  sorted_list_checker #(
    .CAPACITY (LIST_DEPTH)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .replies_owed_o   (replies_owed),
    .list_fill_o      (list_fill)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Flag the input beat taken at the last rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver backpressure: runs of open, sparse, dense and solid stall
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left  = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_style)
      RX_OPEN:  out_stall <= 1'b0;
      RX_HALF:  out_stall <= 1'($urandom_range(0, 1));
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:  out_stall <= (stall_left < 12);
    endcase
  end

  // Drive one beat in bursts with random gaps; hold it until taken
  task automatic send_beat(input slt_pkg::in_t beat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic send_op(input slt_pkg::op_e op, input logic signed [31:0] value,
                         input logic [5:0] position);
    slt_pkg::in_t beat;
    beat.operation = op;
    beat.value     = value;
    beat.position  = position;
    send_beat(beat);
  endtask

  // Hold off the sender until every reply is back
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_owed != 0);
  endtask

  // Mix extremes and a narrow band of duplicates into full-range values
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4, 5:    return 32'(int'($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic slt_pkg::in_t pick_beat(run_kind_e kind, int fill);
    slt_pkg::in_t beat;
    int           roll;
    int           pick;
    beat.value    = pick_value();
    beat.position = 6'($urandom);
    roll          = $urandom_range(0, 99);
    if (kind == NOISE_RUN) begin
      beat.operation = slt_pkg::op_e'($urandom_range(0, 3));
      return beat;
    end
    if ((kind == FILL_RUN && roll < 90) || (kind == DRAIN_RUN && roll >= 80) ||
        (kind == MIXED_RUN && roll < 45)) begin
      beat.operation = $urandom_range(0, 1) ? slt_pkg::SLT_OP_SORTED
                                            : slt_pkg::SLT_OP_APPEND;
    end else if (kind == MIXED_RUN && roll >= 95) begin
      beat.operation = slt_pkg::SLT_OP_CLEAR;
    end else begin
      // mostly live positions, sometimes just past the tail or anywhere
      beat.operation = slt_pkg::SLT_OP_REMOVE;
      pick = $urandom_range(0, 9);
      if (fill > 0 && pick > 1) begin
        beat.position = 6'($urandom_range(0, fill - 1));
      end else if (pick == 1 && fill < LIST_DEPTH) begin
        beat.position = 6'(fill);
      end
    end
    return beat;
  endfunction

  initial begin
    run_kind_e kind;
    int        run_len;
    int        sent;
    sent = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty list, unsorted contents, equal values, range edges
    send_op(slt_pkg::SLT_OP_REMOVE, 32'sd7, 6'd0);
    send_op(slt_pkg::SLT_OP_CLEAR,  32'sd0, 6'd0);
    send_op(slt_pkg::SLT_OP_APPEND, 32'sh7FFF_FFFF, 6'd0);
    send_op(slt_pkg::SLT_OP_APPEND, 32'sh8000_0000, 6'd0);
    send_op(slt_pkg::SLT_OP_SORTED, 32'sd0, 6'd0);
    send_op(slt_pkg::SLT_OP_SORTED, 32'sd5, 6'd0);
    send_op(slt_pkg::SLT_OP_SORTED, 32'sd5, 6'd63);
    send_op(slt_pkg::SLT_OP_SORTED, -32'sd1, 6'd0);
    send_op(slt_pkg::SLT_OP_REMOVE, 32'sd0, 6'd63);
    send_op(slt_pkg::SLT_OP_REMOVE, 32'sd0, 6'd6);
    send_op(slt_pkg::SLT_OP_REMOVE, 32'sd0, 6'd0);
    send_op(slt_pkg::SLT_OP_REMOVE, 32'sd0, 6'd4);
    send_op(slt_pkg::SLT_OP_REMOVE, 32'sd0, 6'd1);
    send_op(slt_pkg::SLT_OP_CLEAR,  -32'sd1, 6'd63);
    send_op(slt_pkg::SLT_OP_SORTED, 32'sh8000_0000, 6'd0);
    send_op(slt_pkg::SLT_OP_SORTED, 32'sh7FFF_FFFF, 6'd0);
    send_op(slt_pkg::SLT_OP_SORTED, 32'sh7FFF_FFFF, 6'd0);
    send_op(slt_pkg::SLT_OP_APPEND, -32'sd1, 6'd0);
    send_op(slt_pkg::SLT_OP_REMOVE, 32'sd0, 6'd3);
    send_op(slt_pkg::SLT_OP_CLEAR,  32'sd0, 6'd0);
    wait_for_replies();

    // Random: first run fills the list past capacity, later runs vary
    kind = FILL_RUN;
    while (sent < RANDOM_ITEMS) begin
      run_len = (kind == FILL_RUN) ? $urandom_range(80, 120) : $urandom_range(15, 60);
      repeat (run_len) begin
        if (sent < RANDOM_ITEMS) begin
          send_beat(pick_beat(kind, list_fill));
          sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        wait_for_replies();
      end
      kind = run_kind_e'($urandom_range(0, 3));
    end

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sorted_list_table.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_cell.sv
rtl/sorted_list_table.sv
rtl/slt_checker.sv
sim/sorted_list_checker.sv
sim/tb_top.sv
